### hw/rtl/tvpc_pkg.sv
// ----------------------------------------------------------------------------
// tvpc_pkg
// Shared types, codes and constants of the tachometer speed controller.
// ----------------------------------------------------------------------------
package tvpc_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned CMD_W    = 8;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned OFFSET_W = 8;
	localparam int unsigned SIGN_W   = 2;
	localparam int unsigned SPEED_W  = 8;
	localparam int unsigned GAIN_W   = 7;
	localparam int unsigned WINDOW_W = 8;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned PROD_W   = SPEED_W + GAIN_W;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 7'd2;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd24;
	localparam logic [SPEED_W-1:0]  EDGE_MAX     = 8'hFF;
	localparam logic [6:0]          OFFSET_MAX   = 7'h7F;

	typedef enum logic [OP_W-1:0] {
		OP_EDGE    = 2'd0,
		OP_TICK    = 2'd1,
		OP_CONTROL = 2'd2
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NEUTRAL  = 2'd0,
		MODE_FORWARD  = 2'd1,
		MODE_BACKWARD = 2'd2
	} mode_t;

	typedef enum logic [SIGN_W-1:0] {
		SIGN_EQUAL    = 2'd0,
		SIGN_TOO_SLOW = 2'd1,
		SIGN_TOO_FAST = 2'd2
	} sign_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 1'd0,
		REG_WINDOW = 1'd1
	} reg_idx_t;

	// A command is a forward speed when it is nonzero and bit 7 is clear.
	function automatic logic is_forward(input logic [CMD_W-1:0] c);
		return (c != '0) && !c[CMD_W-1];
	endfunction

endpackage

### hw/rtl/tvpc_if.sv
// ----------------------------------------------------------------------------
// tvpc_if
// Valid/ready channels for command items and control results.
// ----------------------------------------------------------------------------
interface tvpc_item_if
	import tvpc_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [CMD_W-1:0]  desired_command;

	modport source (output valid, output operation, output desired_command, input ready);
	modport sink   (input valid, input operation, input desired_command, output ready);
endinterface

interface tvpc_result_if
	import tvpc_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   drive_mode;
	logic                reinit_throttle;
	logic [OFFSET_W-1:0] drive_offset;
	logic [SIGN_W-1:0]   error_sign;
	logic [SPEED_W-1:0]  measured_speed;

	modport source (output valid, output drive_mode, output reinit_throttle,
		output drive_offset, output error_sign, output measured_speed, input ready);
	modport sink   (input valid, input drive_mode, input reinit_throttle,
		input drive_offset, input error_sign, input measured_speed, output ready);
endinterface

### hw/rtl/tach_velocity_p_controller.sv
// ----------------------------------------------------------------------------
// tach_velocity_p_controller
// Counts encoder edges over a window of timer ticks and turns speed commands
// into a drive direction, a throttle re-init flag and a proportional offset.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction carries
//  ---------+-----+-----------------------------------------------------------
//  item     | in  | operation, desired_command
//  result   | out | drive_mode, reinit_throttle, drive_offset, error_sign,
//           |     | measured_speed (one per control item)
//  wr_*     | in  | gain / window_limit register writes
//
// One item per cycle unless the entry stage stalls. An item is registered on
// entry; as it leaves the entry stage it updates the counters and, for a
// control item, loads the result register. The result register stalls the
// entry stage only while both are full and result.ready is low. Reset clears
// the counters, previous command and valid flags and loads register defaults.
module tach_velocity_p_controller
	import tvpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tvpc_item_if.sink             item,
	tvpc_result_if.source         result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic [GAIN_W-1:0]   gain_q;
	logic [WINDOW_W-1:0] window_q;
	logic [SPEED_W-1:0]  edge_count_q;
	logic [WINDOW_W-1:0] tick_count_q;
	logic [SPEED_W-1:0]  latched_speed_q;
	logic [CMD_W-1:0]    prev_cmd_q;

	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic [CMD_W-1:0]    cmd_s1;

	logic                valid_s2;
	logic [MODE_W-1:0]   mode_s2;
	logic                reinit_s2;
	logic [OFFSET_W-1:0] offset_s2;
	logic [SIGN_W-1:0]   sign_s2;
	logic [SPEED_W-1:0]  speed_s2;

	logic                advance;
	logic                is_control;
	logic [WINDOW_W:0]   tick_next;
	logic                window_done;
	logic [6:0]          speed_cmd;
	logic [SPEED_W-1:0]  speed_ext;
	logic [SPEED_W-1:0]  diff;
	logic [PROD_W-1:0]   product;
	logic [6:0]          mag;
	sign_t               sign;
	mode_t               mode;
	logic                reinit;

	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign is_control = valid_s1 && (op_t'(op_s1) == OP_CONTROL);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			window_q <= WINDOW_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_GAIN:   gain_q   <= wr_data[GAIN_W-1:0];
				REG_WINDOW: window_q <= wr_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// Entry register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1  <= item.operation;
			cmd_s1 <= item.desired_command;
		end
	end

	// The window closes once the incremented tick count exceeds the limit.
	assign tick_next   = {1'b0, tick_count_q} + {{WINDOW_W{1'b0}}, 1'b1};
	assign window_done = tick_next > {1'b0, window_q};

	// Controller state is updated when the item leaves the entry stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q    <= '0;
			tick_count_q    <= '0;
			latched_speed_q <= '0;
			prev_cmd_q      <= '0;
		end else if (valid_s1 && advance) begin
			unique case (op_t'(op_s1))
				OP_EDGE: begin
					if (edge_count_q != EDGE_MAX)
						edge_count_q <= edge_count_q + 1'b1;
				end
				OP_TICK: begin
					if (window_done) begin
						tick_count_q    <= '0;
						latched_speed_q <= edge_count_q;
						edge_count_q    <= '0;
					end else begin
						tick_count_q <= tick_next[WINDOW_W-1:0];
					end
				end
				OP_CONTROL: prev_cmd_q <= cmd_s1;
				default: ;
			endcase
		end
	end

	// Control law.
	assign speed_cmd = cmd_s1[6:0];
	assign speed_ext = {1'b0, speed_cmd};

	always_comb begin
		if (latched_speed_q > speed_ext) begin
			diff = latched_speed_q - speed_ext;
			sign = SIGN_TOO_FAST;
		end else if (latched_speed_q < speed_ext) begin
			diff = speed_ext - latched_speed_q;
			sign = SIGN_TOO_SLOW;
		end else begin
			diff = '0;
			sign = SIGN_EQUAL;
		end
	end

	assign product = diff * gain_q;
	assign mag     = (product > PROD_W'(OFFSET_MAX)) ? OFFSET_MAX : product[6:0];
	assign mode    = cmd_s1[CMD_W-1] ? MODE_BACKWARD : MODE_FORWARD;
	// A change between two forward speeds keeps the throttle as it is.
	assign reinit  = (cmd_s1 != prev_cmd_q) && !(is_forward(prev_cmd_q) && is_forward(cmd_s1));

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= is_control;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_control) begin
			speed_s2 <= latched_speed_q;
			if (cmd_s1 == '0) begin
				mode_s2   <= MODE_NEUTRAL;
				reinit_s2 <= 1'b0;
				offset_s2 <= '0;
				sign_s2   <= SIGN_EQUAL;
			end else begin
				mode_s2   <= mode;
				reinit_s2 <= reinit;
				offset_s2 <= {(sign == SIGN_TOO_FAST), mag};
				sign_s2   <= sign;
			end
		end
	end

	assign result.valid           = valid_s2;
	assign result.drive_mode      = mode_s2;
	assign result.reinit_throttle = reinit_s2;
	assign result.drive_offset    = offset_s2;
	assign result.error_sign      = sign_s2;
	assign result.measured_speed  = speed_s2;

endmodule
